// File: hdl/pes_pkg.sv
// Package with types and constants for the periodic event scheduler.
package pes_pkg;

    localparam int MAX_EVENTS = 1024;
    localparam int IDX_W = $clog2(MAX_EVENTS);
    localparam int CNT_W = $clog2(MAX_EVENTS + 1);
    localparam int TIME_W = 48;
    localparam int ID_W = 16;
    localparam int PER_W = 16;
    localparam int ENTRY_W = TIME_W + PER_W + ID_W;

    localparam logic FUNC_REGISTER = 1'b0;
    localparam logic FUNC_NEXT = 1'b1;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        logic             func;
        logic [ID_W-1:0]  event_id;
        logic [PER_W-1:0] period;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   due_id;
        logic [TIME_W-1:0] due_time;
        logic [1:0]        status;
    } out_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_val;
        logic [PER_W-1:0]  period;
        logic [ID_W-1:0]   id;
    } entry_t;

    function automatic logic entry_before(entry_t a, entry_t b);
        if (a.time_val != b.time_val)
        begin
            return a.time_val < b.time_val;
        end
        return a.id < b.id;
    endfunction

endpackage

// File: hdl/periodic_event_scheduler.sv
// Top level of the periodic event scheduler: a min-heap held in one memory.
//
//  channel | direction | handshake       | payload
//  in      | input     | in_valid/stall  | in_item  (func, event_id, period)
//  out     | output    | out_valid/stall | out_item (due_id, due_time, status)
//
// A register item climbs the heap level by level; a next item descends it level by level.
// A full heap holds 1024 entries. Reads of the heap memory are registered, and a new item
// is taken only once the block is back in idle and no result waits in the output register.
// Reset empties the heap at once through the entry count; no clearing pass is needed.
// A result waits in the output register while a stalled output holds the next item off.
module periodic_event_scheduler (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pes_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output pes_pkg::out_item_t out_item
);
    import pes_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RD_L, S_DN_RD_R, S_DN_CMP, S_DN_LAST, S_ROOT_RD,
        S_ROOT_WAIT
    } state_t;

    entry_t heap_mem [MAX_EVENTS];

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] best_reg;
    entry_t           cur_reg;
    entry_t           best_ent_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic             mem_re;
    entry_t           mem_rdata;

    logic [CNT_W:0]     l_idx;
    logic [CNT_W:0]     r_idx;
    logic [IDX_W-1:0]   parent;
    logic [TIME_W:0]    sum;
    logic               dn_right;
    entry_t             dn_child;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata <= heap_mem[mem_raddr];
        end
    end

    assign l_idx  = {pos_reg, 1'b1} + (CNT_W + 1)'(0);
    assign r_idx  = l_idx + (CNT_W + 1)'(1);
    assign parent = (pos_reg - IDX_W'(1)) >> 1;
    assign sum    = {1'b0, mem_rdata.time_val} + (TIME_W + 1)'(mem_rdata.period);

    assign dn_right = (r_idx < (CNT_W + 1)'(count_reg)) && entry_before(mem_rdata, best_ent_reg);
    assign dn_child = dn_right ? mem_rdata : best_ent_reg;

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = cur_reg;
        mem_re    = 1'b0;
        mem_raddr = parent;
        case (state_reg)
            S_IDLE:
            begin
                mem_re    = 1'b1;
                mem_raddr = '0;
            end
            S_UP_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = parent;
            end
            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (pos_reg != '0 && entry_before(cur_reg, mem_rdata))
                begin
                    mem_wdata = mem_rdata;
                end
            end
            S_DN_RD_L:
            begin
                mem_re    = 1'b1;
                mem_raddr = l_idx[IDX_W-1:0];
            end
            S_DN_RD_R:
            begin
                mem_re    = 1'b1;
                mem_raddr = r_idx[IDX_W-1:0];
            end
            S_DN_CMP:
            begin
                mem_we    = 1'b1;
                mem_wdata = dn_child;
            end
            S_DN_LAST:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        if (in_item.func == FUNC_REGISTER)
                        begin
                            if (count_reg >= CNT_W'(MAX_EVENTS))
                            begin
                                out_valid_reg <= 1'b1;
                                out_item_reg  <= '{'0, '0, STATUS_FULL};
                            end
                            else
                            begin
                                cur_reg   <= '{TIME_W'(in_item.period), in_item.period,
                                               in_item.event_id};
                                pos_reg   <= count_reg[IDX_W-1:0];
                                count_reg <= count_reg + CNT_W'(1);
                                state_reg <= S_UP_RD;
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            out_valid_reg <= 1'b1;
                            out_item_reg  <= '{'0, '0, STATUS_EMPTY};
                        end
                        else
                        begin
                            state_reg <= S_ROOT_RD;
                        end
                    end
                end
                S_UP_RD:
                begin
                    state_reg <= S_UP_CMP;
                end
                S_UP_CMP:
                begin
                    if (pos_reg != '0 && entry_before(cur_reg, mem_rdata))
                    begin
                        pos_reg   <= parent;
                        state_reg <= S_UP_RD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_ROOT_RD:
                begin
                    out_valid_reg <= 1'b1;
                    out_item_reg  <= '{mem_rdata.id, mem_rdata.time_val, STATUS_OK};
                    cur_reg       <= '{sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0],
                                       mem_rdata.period, mem_rdata.id};
                    pos_reg       <= '0;
                    state_reg     <= S_ROOT_WAIT;
                end
                S_ROOT_WAIT:
                begin
                    if (l_idx < (CNT_W + 1)'(count_reg))
                    begin
                        state_reg <= S_DN_RD_L;
                    end
                    else
                    begin
                        state_reg <= S_DN_LAST;
                    end
                end
                S_DN_RD_L:
                begin
                    state_reg <= S_DN_RD_R;
                end
                S_DN_RD_R:
                begin
                    state_reg <= S_DN_CMP;
                    if (entry_before(mem_rdata, cur_reg))
                    begin
                        best_reg     <= l_idx[IDX_W-1:0];
                        best_ent_reg <= mem_rdata;
                    end
                    else
                    begin
                        best_reg     <= pos_reg;
                        best_ent_reg <= cur_reg;
                    end
                end
                S_DN_CMP:
                begin
                    if (dn_right)
                    begin
                        pos_reg   <= r_idx[IDX_W-1:0];
                        state_reg <= S_ROOT_WAIT;
                    end
                    else if (best_reg != pos_reg)
                    begin
                        pos_reg   <= best_reg;
                        state_reg <= S_ROOT_WAIT;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DN_LAST:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
